// File: design/x86_64_instruction_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder_unit_defines
// Assertion macros for the instruction encoder.
// ----------------------------------------------------------------------------
`ifndef X86_64_INSTRUCTION_ENCODER_UNIT_DEFINES_SVH
`define X86_64_INSTRUCTION_ENCODER_UNIT_DEFINES_SVH

// Implication checked outside reset.
`define X86E_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define X86E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication checked at every edge, reset included.
`define X86E_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/x86e_pkg.sv
// ----------------------------------------------------------------------------
// x86e_pkg
// Shared types and constants of the x86-64 instruction encoder.
// ----------------------------------------------------------------------------
package x86e_pkg;

   localparam int MAX_PREFIX_BYTES = 4;
   localparam int MAX_OPCODE_BYTES = 3;
   localparam int PRE_LIM = (MAX_PREFIX_BYTES < 4) ? MAX_PREFIX_BYTES : 4;
   localparam int OPC_LIM = (MAX_OPCODE_BYTES < 3) ? MAX_OPCODE_BYTES : 3;

   localparam int REQ_DATA_W = 208;
   localparam int NUM_SEG    = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_IMM_RNG = 2'd1;
   localparam logic [1:0] ST_HIGH_REX = 2'd2;

   localparam logic [7:0] BYTE_ASIZE = 8'h67;

   typedef enum logic [2:0] {
      SEG_LEAD  = 3'd0,
      SEG_PRE   = 3'd1,
      SEG_REX   = 3'd2,
      SEG_OPC   = 3'd3,
      SEG_MODRM = 3'd4,
      SEG_SIB   = 3'd5,
      SEG_DISP  = 3'd6,
      SEG_IMM   = 3'd7
   } seg_type;

   // byte-run descriptor handed from the front to the back
   typedef struct packed {
      logic [NUM_SEG-1:0][3:0] len;
      logic [1:0]  status;
      logic [7:0]  lead;
      logic [31:0] pre;
      logic [7:0]  rex;
      logic [23:0] opc;
      logic [7:0]  modrm;
      logic [7:0]  sib;
      logic [31:0] disp;
      logic [63:0] imm;
   } desc_type;

endpackage

// File: design/x86_64_instruction_encoder_unit.sv
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder_unit
// Encodes one x86-64 instruction request into its machine code byte run.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one instruction request per handshake; rsp_* returns its
//   code bytes one per handshake, rsp_tlast on the final byte of a run.
//   A request with an out-of-range immediate or a high-byte register under
//   REX returns a single zero byte with rsp_tlast set and the code in
//   rsp_tuser; a request that encodes to nothing returns no byte.
//   Path: queue entry, walker descriptor register, output byte register.
//   Throughput: one byte per cycle while rsp_tready is high;
//   the byte walker loads the next request at the edge that issues the last
//   byte of the previous one, so runs follow with no gap. The front
//   classifies combinationally and a two-entry descriptor queue decouples
//   it from the walker.
//   Reset clears the queue, the walker's active flag and the output valid.
//   When rsp_tready is low the output byte holds; the queue keeps taking
//   requests until its two entries are full, then req_tready drops.
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // opcode_bytes, opcode_count, prefix_bytes, prefix_count, fixed_rex,
   // fixed_modrm, form_bits, immediate, reg_low, reg_field,
   // address_select, displacement, zero pad
   input  logic [x86e_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // code_byte
   output logic                            rsp_tlast,
   output logic [1:0]                      rsp_tuser   // status
);
   import x86e_pkg::*;

   desc_type front_desc;
   desc_type q_head;
   logic     q_not_full;
   logic     q_not_empty;
   logic     q_pop;

   x86e_front u_front (
      .req_data (req_tdata),
      .desc     (front_desc)
   );

   x86e_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_desc (front_desc),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   x86e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = q_not_full;

endmodule

// File: design/x86e_front.sv
// ----------------------------------------------------------------------------
// x86e_front
// Classifies one instruction request into a byte-run descriptor.
// ----------------------------------------------------------------------------
module x86e_front (
   input  logic [x86e_pkg::REQ_DATA_W-1:0] req_data,
   output x86e_pkg::desc_type              desc
);
   import x86e_pkg::*;

   logic [23:0] opc;
   logic [1:0]  opc_n;
   logic [31:0] pre;
   logic [2:0]  pre_n;
   logic [7:0]  rex_fix;
   logic [7:0]  modrm_fix;
   logic [7:0]  form;
   logic [63:0] imm;
   logic [4:0]  rl;
   logic [4:0]  rf;
   logic [12:0] asel;
   logic [31:0] disp;
   logic [4:0]  base;
   logic [4:0]  index;
   logic [1:0]  scale;
   logic        mem;
   logic        use_rl;
   logic        use_rf;
   logic [2:0]  isize;
   logic        imm_bad;
   logic [63:0] imm_max;
   logic [63:0] imm_min;
   logic [7:0]  rex;
   logic [7:0]  m;
   logic        no_base;
   logic        has_index;
   logic [2:0]  b;
   logic        short_disp;
   logic        disp_zero;

   assign opc       = req_data[23:0];
   assign opc_n     = req_data[25:24];
   assign pre       = req_data[57:26];
   assign pre_n     = req_data[60:58];
   assign rex_fix   = req_data[68:61];
   assign modrm_fix = req_data[76:69];
   assign form      = req_data[84:77];
   assign imm       = req_data[148:85];
   assign rl        = req_data[153:149];
   assign rf        = req_data[158:154];
   assign asel      = req_data[171:159];
   assign disp      = req_data[203:172];

   assign base      = asel[4:0];
   assign index     = asel[9:5];
   assign scale     = asel[11:10];
   assign mem       = form[0];
   assign use_rl    = form[1];
   assign use_rf    = form[2];
   assign isize     = form[7:5];
   assign no_base   = base > 5'd16;
   assign has_index = index < 5'd16;
   assign b         = base[2:0];
   assign short_disp = (disp <= 32'h7f) || (disp >= 32'hffffff80);
   assign disp_zero = disp == 32'd0;

   always_comb begin
      imm_max = 64'd0;
      imm_min = 64'd0;
      case (isize)
         3'd1: begin
            imm_max = form[4] ? 64'hff : 64'h7f;
            imm_min = 64'hffffffffffffff80;
         end
         3'd2: begin
            imm_max = form[4] ? 64'hffff : 64'h7fff;
            imm_min = 64'hffffffffffff8000;
         end
         3'd3: begin
            imm_max = form[4] ? 64'hffffffff : 64'h7fffffff;
            imm_min = 64'hffffffff80000000;
         end
         default: begin
            imm_max = 64'd0;
            imm_min = 64'd0;
         end
      endcase
      imm_bad = (imm > imm_max) && (imm < imm_min);
   end

   always_comb begin
      rex = rex_fix;
      m   = modrm_fix;
      if (mem) begin
         if (base >= 5'd8 && base < 5'd16) rex = rex | 8'h41;
         if (index >= 5'd8 && index < 5'd16) rex = rex | 8'h42;
      end
      if (use_rl) begin
         if (rl >= 5'd8 && rl < 5'd16) rex = rex | 8'h41;
         if (rl >= 5'd20 && rl < 5'd24) rex = rex | 8'h40;
         m = m | {5'd0, rl[2:0]};
      end
      if (use_rf) begin
         if (rf >= 5'd8 && rf < 5'd16) rex = rex | 8'h44;
         if (rf >= 5'd20 && rf < 5'd24) rex = rex | 8'h40;
         m = m | {2'd0, rf[2:0], 3'd0};
      end
   end

   always_comb begin
      desc = '0;
      desc.pre  = pre;
      desc.opc  = opc;
      desc.rex  = rex;
      desc.disp = disp;
      desc.imm  = imm;
      desc.lead = BYTE_ASIZE;
      if (imm_bad) begin
         desc.status = ST_IMM_RNG;
      end else if (rex != 8'd0 && ((use_rl && rl >= 5'd28) || (use_rf && rf >= 5'd28))) begin
         desc.status = ST_HIGH_REX;
      end else begin
         desc.status = ST_OK;
      end
      if (desc.status != ST_OK) begin
         desc.lead = 8'd0;
         desc.len[SEG_LEAD] = 4'd1;
      end else begin
         desc.len[SEG_LEAD] = {3'd0, mem & asel[12]};
         desc.len[SEG_PRE]  = (pre_n > 3'(PRE_LIM)) ? 4'(PRE_LIM) : {1'b0, pre_n};
         desc.len[SEG_REX]  = {3'd0, rex != 8'd0};
         desc.len[SEG_OPC]  = ({1'b0, opc_n} > 3'(OPC_LIM)) ? 4'(OPC_LIM) : {2'd0, opc_n};
         case (isize)
            3'd1:    desc.len[SEG_IMM] = 4'd1;
            3'd2:    desc.len[SEG_IMM] = 4'd2;
            3'd3:    desc.len[SEG_IMM] = 4'd4;
            3'd4:    desc.len[SEG_IMM] = 4'd8;
            default: desc.len[SEG_IMM] = 4'd0;
         endcase
         if (mem) begin
            desc.len[SEG_MODRM] = 4'd1;
            if (no_base) begin
               desc.modrm = m | 8'h04;
               desc.sib   = has_index ? {scale, index[2:0], 3'b101} : 8'h25;
               desc.len[SEG_SIB]  = 4'd1;
               desc.len[SEG_DISP] = 4'd4;
            end else if (base == 5'd16) begin
               desc.modrm = m | 8'h05;
               desc.len[SEG_DISP] = 4'd4;
            end else if (!has_index) begin
               desc.sib = 8'h24;
               desc.len[SEG_SIB] = {3'd0, b == 3'd4};
               if (disp_zero && b != 3'd5) begin
                  desc.modrm = m | {5'd0, b};
               end else if (short_disp) begin
                  desc.modrm = m | 8'h40 | {5'd0, b};
                  desc.len[SEG_DISP] = 4'd1;
               end else begin
                  desc.modrm = m | 8'h80 | {5'd0, b};
                  desc.len[SEG_DISP] = 4'd4;
               end
            end else begin
               desc.sib = {scale, index[2:0], b};
               desc.len[SEG_SIB] = 4'd1;
               if (disp_zero && b != 3'd5) begin
                  desc.modrm = m | 8'h04;
               end else if (short_disp) begin
                  desc.modrm = m | 8'h44;
                  desc.len[SEG_DISP] = 4'd1;
               end else begin
                  desc.modrm = m | 8'h84;
                  desc.len[SEG_DISP] = 4'd4;
               end
            end
         end else if (form[3]) begin
            desc.modrm = m | 8'hc0;
            desc.len[SEG_MODRM] = 4'd1;
         end
      end
   end

endmodule

// File: design/x86e_queue.sv
// ----------------------------------------------------------------------------
// x86e_queue
// Short descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module x86e_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  x86e_pkg::desc_type push_desc,
   output logic               not_full,
   input  logic               pop,
   output logic               not_empty,
   output x86e_pkg::desc_type head
);
   import x86e_pkg::*;

   desc_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push;
   logic                do_pop;

   assign not_full  = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head      = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_desc;
   end

endmodule

// File: design/x86e_back.sv
// ----------------------------------------------------------------------------
// x86e_back
// Walks a descriptor segment by segment, one code byte per cycle unless rsp_tready stalls.
// ----------------------------------------------------------------------------
module x86e_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  x86e_pkg::desc_type q_head,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output logic [1:0]         rsp_tuser
);
   import x86e_pkg::*;

   logic      active_ff, active_in;
   desc_type  desc_ff, desc_in;
   seg_type   seg_ff, seg_in;
   logic [2:0] idx_ff, idx_in;
   logic      valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic      last_ff, last_in;
   logic [1:0] user_ff, user_in;

   logic      fire;
   logic      end_seg;
   logic      nxt_any;
   seg_type   nxt_seg;
   logic      head_any;
   seg_type   head_seg;
   logic      is_last;
   logic      load_ok;
   logic [7:0] cur_byte;
   logic [3:0] cur_len;

   assign fire    = active_ff && (!valid_ff || rsp_tready);
   assign cur_len = desc_ff.len[seg_ff];
   assign end_seg = ({1'b0, idx_ff} + 4'd1) == cur_len;
   assign is_last = end_seg && !nxt_any;
   assign load_ok = !active_ff || (fire && is_last);
   assign q_pop   = load_ok && q_valid;

   always_comb begin
      nxt_any  = 1'b0;
      nxt_seg  = SEG_LEAD;
      head_any = 1'b0;
      head_seg = SEG_LEAD;
      for (int i = NUM_SEG - 1; i >= 0; i--) begin
         if (3'(i) > seg_ff && desc_ff.len[i] != 4'd0) begin
            nxt_any = 1'b1;
            nxt_seg = seg_type'(3'(i));
         end
         if (q_head.len[i] != 4'd0) begin
            head_any = 1'b1;
            head_seg = seg_type'(3'(i));
         end
      end
   end

   always_comb begin
      case (seg_ff)
         SEG_LEAD:  cur_byte = desc_ff.lead;
         SEG_PRE:   cur_byte = desc_ff.pre[8*idx_ff[1:0] +: 8];
         SEG_REX:   cur_byte = desc_ff.rex;
         SEG_OPC:   cur_byte = (idx_ff[1:0] == 2'd3) ? 8'd0 : desc_ff.opc[8*idx_ff[1:0] +: 8];
         SEG_MODRM: cur_byte = desc_ff.modrm;
         SEG_SIB:   cur_byte = desc_ff.sib;
         SEG_DISP:  cur_byte = desc_ff.disp[8*idx_ff[1:0] +: 8];
         SEG_IMM:   cur_byte = desc_ff.imm[8*idx_ff +: 8];
         default:   cur_byte = 8'd0;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      desc_in   = desc_ff;
      seg_in    = seg_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      user_in   = user_ff;
      if (fire) begin
         valid_in = 1'b1;
         data_in  = cur_byte;
         last_in  = is_last;
         user_in  = desc_ff.status;
         if (!end_seg) begin
            idx_in = idx_ff + 3'd1;
         end else if (nxt_any) begin
            seg_in = nxt_seg;
            idx_in = 3'd0;
         end else begin
            active_in = 1'b0;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (q_pop && head_any) begin
         active_in = 1'b1;
         desc_in   = q_head;
         seg_in    = head_seg;
         idx_in    = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      seg_ff  <= seg_in;
      idx_ff  <= idx_in;
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

// File: design/x86e_checker.sv
// ----------------------------------------------------------------------------
// x86e_checker
// Port-level checks on the instruction encoder.
// ----------------------------------------------------------------------------
`include "x86_64_instruction_encoder_unit_defines.svh"

module x86e_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);
   import x86e_pkg::*;

   `X86E_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp byte dropped while stalled")
   `X86E_ASSERT_IMPLY(a_err_single, clock, reset, rsp_tvalid && rsp_tuser != ST_OK, rsp_tlast && rsp_tdata == 8'd0, "error result not a single zero byte")
   `X86E_ASSERT_IMPLY(a_status_code, clock, reset, rsp_tvalid, rsp_tuser <= ST_HIGH_REX, "undefined status code")
   `X86E_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset), !rsp_tvalid, "rsp valid right after reset")

endmodule

bind x86_64_instruction_encoder_unit x86e_checker u_x86e_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
